/* hw/rtl/sob_pkg.sv */
// ----------------------------------------------------------------------------
// sob_pkg
// shared widths, sine polynomial constants, register indexes and the
// command and status bundles between controller and datapath
// ----------------------------------------------------------------------------
package sob_pkg;

   localparam int PHASE_W = 32;
   localparam int FREQ_W  = 48;
   localparam int STEP_W  = 50;
   localparam int BASE_W  = 31;
   localparam int LEN_W   = 13;
   localparam int OUT_W   = 16;
   localparam int DIVN_W  = 49;
   localparam int DIVD_W  = 13;

   localparam logic [31:0] SIN_A = 32'd51472;
   localparam logic [31:0] SIN_B = 32'd21315;
   localparam logic [31:0] SIN_C = 32'd2611;

   localparam logic CSR_VOICE_COUNT = 1'b0;
   localparam logic CSR_MIN_INC     = 1'b1;

   typedef struct packed {
      logic load;
      logic zero_res;
      logic div_tgt;
      logic div_step;
      logic div_avg;
      logic cap_tgt;
      logic cap_step;
      logic cap_avg;
      logic sin0;
      logic sin1;
      logic sin2;
      logic sin3;
      logic sin4;
      logic out_load;
   } sob_cmd_type;

   typedef struct packed {
      logic div_done;
      logic no_voices;
      logic last_voice;
   } sob_stat_type;

endpackage

/* hw/rtl/sob_div.sv */
// ----------------------------------------------------------------------------
// sob_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module sob_div import sob_pkg::*; #(
   parameter int NUM_W = 49,
   parameter int DEN_W = 13
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   shifted;

   always_comb begin
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      shifted = {rem_ff, quo_ff[NUM_W-1]};
      if (start) begin
         cnt_in = CNT_W'(NUM_W);
         quo_in = dividend;
         rem_in = '0;
         den_in = divisor;
      end else if (cnt_ff != '0) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = DEN_W'(shifted - {1'b0, den_ff});
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* hw/rtl/sob_datapath.sv */
// ----------------------------------------------------------------------------
// sob_datapath
// voice state, configuration registers, sine evaluation, glide arithmetic
// and the shared divider
// ----------------------------------------------------------------------------
module sob_datapath import sob_pkg::*; #(
   parameter int MAX_VOICE_COUNT  = 8,
   parameter int SINE_TABLE_DEPTH = 1024,
   parameter int IW               = 3
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write,
   input  logic                     csr_index,
   input  logic [BASE_W-1:0]        csr_wdata,
   input  logic [BASE_W-1:0]        req_base_increment,
   input  logic [LEN_W-1:0]         req_block_length,
   input  sob_cmd_type              cmd,
   input  logic [IW-1:0]            voice_idx,
   output sob_stat_type             stat,
   output logic signed [OUT_W-1:0]  rsp_sample
);

   localparam int NV_W    = $clog2(MAX_VOICE_COUNT + 1);
   localparam int SUM_W   = $clog2(MAX_VOICE_COUNT) + 17;
   localparam int PHASE_L = $clog2(SINE_TABLE_DEPTH);
   localparam logic [PHASE_W-1:0] PHASE_MASK =
      ~((PHASE_W'(1) << (PHASE_W - PHASE_L)) - PHASE_W'(1));
   localparam logic [FREQ_W-1:0] FREQ_MAX = '1;

   logic [3:0]             voice_count_ff;
   logic [BASE_W-1:0]      min_inc_ff;
   logic [PHASE_W-1:0]     phase_ff [MAX_VOICE_COUNT];
   logic [FREQ_W-1:0]      freq_ff  [MAX_VOICE_COUNT];
   logic signed [STEP_W-1:0] step_ff [MAX_VOICE_COUNT];
   logic [BASE_W-1:0]      base_ff;
   logic [LEN_W-1:0]       len_ff;
   logic                   diff_neg_ff;
   logic [DIVN_W-1:0]      diff_mag_ff;
   logic [15:0]            z_ff, z2_ff, t1_ff, t_ff;
   logic                   neg_half_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic [OUT_W-1:0]       res_ff;
   logic [OUT_W-1:0]       rsp_sample_ff;

   logic [NV_W-1:0]        n_act;
   logic                   div_start, div_done;
   logic [DIVN_W-1:0]      div_num, div_quo;
   logic [DIVD_W-1:0]      div_den;
   logic [SUM_W-1:0]       sum_mag;
   logic [46:0]            tgt_v;
   logic [46:0]            floor_v;
   logic signed [STEP_W-1:0] diff_v;
   logic signed [STEP_W-1:0] quo_s;
   logic [PHASE_W-1:0]     q_v;
   logic [30:0]            r_v;
   logic [31:0]            y_full;
   logic [15:0]            y_sat;
   logic signed [SUM_W-1:0] y_s;
   logic signed [STEP_W:0] f_v;
   logic [FREQ_W-1:0]      f_clamp;
   logic [OUT_W-1:0]       avg_v;

   assign n_act = (32'(voice_count_ff) > 32'(MAX_VOICE_COUNT)) ?
                  NV_W'(MAX_VOICE_COUNT) : NV_W'(voice_count_ff);

   assign stat.no_voices  = (n_act == '0);
   assign stat.last_voice = (32'(voice_idx) + 32'd1 == 32'(n_act));
   assign stat.div_done   = div_done;

   assign sum_mag = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);

   assign div_start = cmd.div_tgt | cmd.div_step | cmd.div_avg;

   always_comb begin
      if (cmd.div_tgt) begin
         div_num = DIVN_W'({base_ff, 16'b0});
         div_den = DIVD_W'(voice_idx) + DIVD_W'(1);
      end else if (cmd.div_step) begin
         div_num = diff_mag_ff;
         div_den = len_ff;
      end else begin
         div_num = DIVN_W'(sum_mag);
         div_den = DIVD_W'(n_act);
      end
   end

   sob_div #(
      .NUM_W(DIVN_W),
      .DEN_W(DIVD_W)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(div_num),
      .divisor (div_den),
      .done    (div_done),
      .quotient(div_quo)
   );

   // target clamp and signed difference to the current frequency
   always_comb begin
      floor_v = {min_inc_ff, 16'b0};
      tgt_v   = div_quo[46:0];
      if (voice_idx != '0 && tgt_v < floor_v)
         tgt_v = floor_v;
      diff_v = $signed({3'b0, tgt_v}) - $signed({2'b0, freq_ff[voice_idx]});
      quo_s  = $signed({1'b0, div_quo});
      if (diff_neg_ff)
         quo_s = -quo_s;
   end

   // quarter-wave fold of the quantised phase
   always_comb begin
      q_v = phase_ff[voice_idx] & PHASE_MASK;
      r_v = {1'b0, q_v[29:0]};
      if (q_v[30])
         r_v = 31'h4000_0000 - r_v;
   end

   always_comb begin
      y_full = (32'(z_ff) * 32'(t_ff)) >> 15;
      y_sat  = (y_full > 32'd32767) ? 16'd32767 : y_full[15:0];
      y_s    = neg_half_ff ? -$signed(SUM_W'(y_sat)) : $signed(SUM_W'(y_sat));
      f_v    = $signed({3'b0, freq_ff[voice_idx]})
             + $signed({step_ff[voice_idx][STEP_W-1], step_ff[voice_idx]});
      if (f_v < 0)
         f_clamp = '0;
      else if (f_v > $signed({3'b0, FREQ_MAX}))
         f_clamp = FREQ_MAX;
      else
         f_clamp = f_v[FREQ_W-1:0];
      avg_v = sum_ff[SUM_W-1] ? OUT_W'(-div_quo[OUT_W-1:0]) : div_quo[OUT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         voice_count_ff <= 4'd8;
         min_inc_ff     <= '0;
         for (int i = 0; i < MAX_VOICE_COUNT; i++) begin
            phase_ff[i] <= '0;
            freq_ff[i]  <= '0;
            step_ff[i]  <= '0;
         end
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_VOICE_COUNT: voice_count_ff <= csr_wdata[3:0];
               CSR_MIN_INC:     min_inc_ff     <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.cap_step)
            step_ff[voice_idx] <= quo_s;
         if (cmd.sin4) begin
            freq_ff[voice_idx]  <= f_clamp;
            phase_ff[voice_idx] <= phase_ff[voice_idx] + f_clamp[FREQ_W-1:16];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         base_ff <= req_base_increment;
         len_ff  <= (req_block_length == '0) ? LEN_W'(1) : req_block_length;
         sum_ff  <= '0;
      end
      if (cmd.cap_tgt) begin
         diff_neg_ff <= diff_v[STEP_W-1];
         diff_mag_ff <= diff_v[STEP_W-1] ? DIVN_W'(-diff_v) : DIVN_W'(diff_v);
      end
      if (cmd.sin0) begin
         z_ff        <= r_v[30:15];
         neg_half_ff <= q_v[31];
      end
      if (cmd.sin1)
         z2_ff <= 16'((32'(z_ff) * 32'(z_ff)) >> 15);
      if (cmd.sin2)
         t1_ff <= 16'(SIN_B - ((SIN_C * 32'(z2_ff)) >> 15));
      if (cmd.sin3)
         t_ff <= 16'(SIN_A - ((32'(z2_ff) * 32'(t1_ff)) >> 15));
      if (cmd.sin4)
         sum_ff <= sum_ff + y_s;
      if (cmd.zero_res)
         res_ff <= '0;
      else if (cmd.cap_avg)
         res_ff <= avg_v;
      if (cmd.out_load)
         rsp_sample_ff <= res_ff;
   end

   assign rsp_sample = $signed(rsp_sample_ff);

endmodule

/* hw/rtl/sob_ctrl.sv */
// ----------------------------------------------------------------------------
// sob_ctrl
// sequencer: glide setup per voice, sine and update per voice, averaging
// and the result handshake
// ----------------------------------------------------------------------------
module sob_ctrl import sob_pkg::*; #(
   parameter int IW = 3
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic          req_block_start,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  sob_stat_type  stat,
   output sob_cmd_type   cmd,
   output logic [IW-1:0] voice_idx
);

   typedef enum logic [3:0] {
      IDLE, TGT_GO, TGT_WAIT, STEP_GO, STEP_WAIT,
      SIN0, SIN1, SIN2, SIN3, SIN4, AVG_GO, AVG_WAIT, OUT
   } state_type;

   state_type     state_ff;
   logic [IW-1:0] idx_ff;
   logic          rsp_valid_ff;
   logic          accept;
   logic          out_free;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         IDLE: begin
            cmd.load     = accept;
            cmd.zero_res = accept && stat.no_voices;
         end
         TGT_GO:    cmd.div_tgt  = 1'b1;
         TGT_WAIT:  cmd.cap_tgt  = stat.div_done;
         STEP_GO:   cmd.div_step = 1'b1;
         STEP_WAIT: cmd.cap_step = stat.div_done;
         SIN0:      cmd.sin0     = 1'b1;
         SIN1:      cmd.sin1     = 1'b1;
         SIN2:      cmd.sin2     = 1'b1;
         SIN3:      cmd.sin3     = 1'b1;
         SIN4:      cmd.sin4     = 1'b1;
         AVG_GO:    cmd.div_avg  = 1'b1;
         AVG_WAIT:  cmd.cap_avg  = stat.div_done;
         OUT:       cmd.out_load = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == OUT && out_free)
            rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall)
            rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            IDLE: begin
               idx_ff <= '0;
               if (accept) begin
                  if (stat.no_voices)
                     state_ff <= OUT;
                  else if (req_block_start)
                     state_ff <= TGT_GO;
                  else
                     state_ff <= SIN0;
               end
            end
            TGT_GO:   state_ff <= TGT_WAIT;
            TGT_WAIT: if (stat.div_done) state_ff <= STEP_GO;
            STEP_GO:  state_ff <= STEP_WAIT;
            STEP_WAIT: begin
               if (stat.div_done) begin
                  if (stat.last_voice) begin
                     idx_ff   <= '0;
                     state_ff <= SIN0;
                  end else begin
                     idx_ff   <= idx_ff + 1'b1;
                     state_ff <= TGT_GO;
                  end
               end
            end
            SIN0: state_ff <= SIN1;
            SIN1: state_ff <= SIN2;
            SIN2: state_ff <= SIN3;
            SIN3: state_ff <= SIN4;
            SIN4: begin
               if (stat.last_voice) begin
                  state_ff <= AVG_GO;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= SIN0;
               end
            end
            AVG_GO:   state_ff <= AVG_WAIT;
            AVG_WAIT: if (stat.div_done) state_ff <= OUT;
            OUT: begin
               if (out_free)
                  state_ff <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   // no transaction is taken while reset is held
   assign req_stall = reset || (state_ff != IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign voice_idx = idx_ff;

   a_out_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("result overwritten while stalled");

   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      stat.div_done |-> (state_ff == TGT_WAIT || state_ff == STEP_WAIT ||
                         state_ff == AVG_WAIT))
      else $error("divider finished outside a wait state");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != IDLE)
      else $error("accepted transaction not started");

endmodule

/* hw/rtl/subharmonic_oscillator_bank_core.sv */
// ----------------------------------------------------------------------------
// subharmonic_oscillator_bank_core
// bank of gliding sine voices, one averaged sample per sample tick
// ----------------------------------------------------------------------------
//  channel  direction  ports                                     handshake
//  req      in         block_start, base_increment, block_length valid/stall
//  rsp      out        sample                                    valid/stall
//  csr      in         index, wdata                              write strobe
//
//  with n active voices a plain tick runs the sine steps for each voice and
//  one averaging division, and a block start adds two divider passes per voice;
//  the shared one-bit-per-cycle divider sets most of the transaction time
//  zero voices: result zero; reset clears all voice state at once
//  a finished result waits in the output register while the next
//  transaction is accepted
// ----------------------------------------------------------------------------
module subharmonic_oscillator_bank_core import sob_pkg::*; #(
   parameter int MAX_VOICE_COUNT  = 8,
   parameter int SINE_TABLE_DEPTH = 1024
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write,
   input  logic                    csr_index,
   input  logic [BASE_W-1:0]       csr_wdata,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_block_start,
   input  logic [BASE_W-1:0]       req_base_increment,
   input  logic [LEN_W-1:0]        req_block_length,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [OUT_W-1:0] rsp_sample
);

   localparam int IW = (MAX_VOICE_COUNT > 1) ? $clog2(MAX_VOICE_COUNT) : 1;

   sob_cmd_type   cmd;
   sob_stat_type  stat;
   logic [IW-1:0] voice_idx;

   sob_ctrl #(
      .IW(IW)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_block_start(req_block_start),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .stat           (stat),
      .cmd            (cmd),
      .voice_idx      (voice_idx)
   );

   sob_datapath #(
      .MAX_VOICE_COUNT (MAX_VOICE_COUNT),
      .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
      .IW              (IW)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_base_increment(req_base_increment),
      .req_block_length  (req_block_length),
      .cmd               (cmd),
      .voice_idx         (voice_idx),
      .stat              (stat),
      .rsp_sample        (rsp_sample)
   );

endmodule

/* sim/subharmonic_oscillator_bank_core_tb.sv */
// ----------------------------------------------------------------------------
// subharmonic_oscillator_bank_core_tb
// drives sample ticks and block starts into the oscillator bank with random
// idling on both sides, predicts every averaged sample and checks it in order
// ----------------------------------------------------------------------------
module subharmonic_oscillator_bank_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sob_pkg::*;

   localparam int NV = 8;
   localparam int TDEPTH = 1024;
   localparam longint FMAX = (64'sd1 <<< 48) - 1;
   localparam longint LIMIT = 64'd12000000;

   // bank predictor and queue of expected samples
   class sample_scoreboard;
      int unsigned n_voices;
      longint unsigned min_inc;
      bit [31:0] phase [NV];
      longint freq [NV];
      longint glide [NV];
      logic signed [OUT_W-1:0] pending [$];
      int errors;
      int checked;

      function new();
         n_voices = 8;
         min_inc = 0;
         errors = 0;
         checked = 0;
         for (int i = 0; i < NV; i++) begin
            phase[i] = 0;
            freq[i] = 0;
            glide[i] = 0;
         end
      endfunction

      function int sine_of(bit [31:0] p);
         longint unsigned k, z, z2, t, y;
         bit [31:0] q, r;
         k = ({32'd0, p} * TDEPTH) >> 32;
         q = 32'((k << 32) / TDEPTH);
         r = q & 32'h3fff_ffff;
         if (q[30]) r = 32'h4000_0000 - r;
         z = r >> 15;
         z2 = (z * z) >> 15;
         t = 64'd21315 - ((64'd2611 * z2) >> 15);
         t = 64'd51472 - ((z2 * t) >> 15);
         y = (z * t) >> 15;
         if (y > 32767) y = 32767;
         return q[31] ? -int'(y) : int'(y);
      endfunction

      function void note_tick(bit start, bit [BASE_W-1:0] base, bit [LEN_W-1:0] len);
         int unsigned n;
         int sum;
         longint len_s, f;
         longint unsigned tgt;
         n = (n_voices > NV) ? NV : n_voices;
         sum = 0;
         if (n == 0) begin
            pending.push_back('0);
            return;
         end
         if (start) begin
            len_s = (len == 0) ? 1 : len;
            for (int i = 0; i < n; i++) begin
               tgt = ({33'd0, base} << 16) / (i + 1);
               if (i > 0 && tgt < (min_inc << 16)) tgt = min_inc << 16;
               glide[i] = (longint'(tgt) - freq[i]) / len_s;
            end
         end
         for (int i = 0; i < n; i++) begin
            sum += sine_of(phase[i]);
            f = freq[i] + glide[i];
            if (f < 0) f = 0;
            if (f > FMAX) f = FMAX;
            freq[i] = f;
            phase[i] = phase[i] + 32'(f >>> 16);
         end
         sum = sum / int'(n);
         pending.push_back(OUT_W'(sum));
      endfunction

      function void check_sample(logic signed [OUT_W-1:0] got);
         logic signed [OUT_W-1:0] want;
         if (pending.size() == 0) begin
            $error("unexpected sample transaction: sample=%0d", got);
            errors++;
            return;
         end
         want = pending.pop_front();
         checked++;
         if (got !== want) begin
            $error("sample mismatch: expected %0d actual %0d", want, got);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_write = 0;
   logic csr_index = CSR_VOICE_COUNT;
   logic [BASE_W-1:0] csr_wdata = '0;
   logic req_valid = 0;
   logic req_stall;
   logic req_block_start = 0;
   logic [BASE_W-1:0] req_base_increment = '0;
   logic [LEN_W-1:0] req_block_length = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [OUT_W-1:0] rsp_sample;

   sample_scoreboard sb = new();
   longint cycles = 0;
   bit calm = 0;
   int starts = 0;

   always #5 clock = ~clock;

   subharmonic_oscillator_bank_core u_top (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_block_start(req_block_start), .req_base_increment(req_base_increment),
      .req_block_length(req_block_length),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_sample(rsp_sample)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAIL");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) sb.check_sample(rsp_sample);
   end

   always @(negedge clock) begin
      rsp_stall <= !calm && !reset && ($urandom_range(99) < 10);
   end

   task automatic write_reg(logic idx, logic [BASE_W-1:0] val);
      @(negedge clock);
      csr_write <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_write <= 0;
      if (idx == CSR_VOICE_COUNT) sb.n_voices = val[3:0];
      else sb.min_inc = val;
   endtask

   task automatic send_tick(bit start, logic [BASE_W-1:0] base, logic [LEN_W-1:0] len);
      @(negedge clock);
      while (!calm && $urandom_range(99) < 10) @(negedge clock);
      req_valid <= 1;
      req_block_start <= start;
      req_base_increment <= base;
      req_block_length <= len;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_tick(start, base, len);
      starts += start;
      @(negedge clock);
      req_valid <= 0;
   endtask

   task automatic wait_drain();
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (1000) @(posedge clock);
   endtask

   // a random block: start tick then a few plain ticks
   task automatic random_block();
      int unsigned len;
      logic [BASE_W-1:0] base;
      len = ($urandom_range(9) == 0) ? $urandom_range(8191) : $urandom_range(12);
      base = ($urandom_range(3) == 0) ? BASE_W'($urandom) :
             BASE_W'($urandom_range(32'h0200_0000));
      send_tick(1, base, LEN_W'(len));
      repeat ($urandom_range(8)) send_tick(0, BASE_W'($urandom), LEN_W'($urandom));
   endtask

   initial begin
      int unsigned vc;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: glide from zero, extremes of base and length, zero length
      send_tick(0, '0, '0);
      send_tick(1, {BASE_W{1'b1}}, 13'd1);
      send_tick(0, '0, '0);
      send_tick(1, '0, 13'd0);
      send_tick(0, '0, '0);
      send_tick(1, 31'h0100_0000, 13'd4096);
      send_tick(1, 31'h0100_0000, {LEN_W{1'b1}});
      send_tick(0, {BASE_W{1'b1}}, {LEN_W{1'b1}});
      // overshoot after the block ends saturates frequency
      send_tick(1, {BASE_W{1'b1}}, 13'd2);
      repeat (4) send_tick(0, '0, '0);
      send_tick(1, '0, 13'd1);
      repeat (3) send_tick(0, '0, '0);
      wait_drain();
      write_reg(CSR_MIN_INC, {BASE_W{1'b1}});
      send_tick(1, 31'h0000_1000, 13'd3);
      send_tick(0, '0, '0);
      wait_drain();
      write_reg(CSR_VOICE_COUNT, 31'd0);
      send_tick(1, 31'h1234_5678, 13'd5);
      send_tick(0, '0, '0);
      wait_drain();
      write_reg(CSR_VOICE_COUNT, 31'd15);
      send_tick(1, 31'h0010_0000, 13'd2);
      send_tick(0, '0, '0);
      wait_drain();
      write_reg(CSR_VOICE_COUNT, 31'd1);
      write_reg(CSR_MIN_INC, '0);
      send_tick(1, 31'h0400_0000, 13'd1);
      send_tick(0, '0, '0);
      wait_drain();

      // random phases with varying voice count and floor
      for (int ph = 0; ph < 12; ph++) begin
         vc = (ph == 0) ? 8 : (ph == 1) ? 0 : (ph == 2) ? 1 : $urandom_range(15);
         write_reg(CSR_VOICE_COUNT, BASE_W'(vc));
         write_reg(CSR_MIN_INC, (ph == 3) ? {BASE_W{1'b1}} : (ph == 4) ? '0 :
                   BASE_W'($urandom_range(32'h0080_0000)));
         calm = (ph == 5);
         while (sb.checked < 30 + (ph + 1) * 170) begin
            if ($urandom_range(9) == 0)
               send_tick(0, BASE_W'($urandom), LEN_W'($urandom));
            else
               random_block();
            while (sb.pending.size() > 4) @(posedge clock);
         end
         calm = 0;
         wait_drain();
      end

      $display("ran %0d sample transactions, %0d block starts, voice counts 0 to 15",
               sb.checked, starts);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
